/* rtl/core/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// Linear blend skinning package
// Shared item types, action codes, pipeline stage control and the clamp helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  typedef enum logic [1:0] {
    ACT_POSE = 2'd0,
    ACT_INV  = 2'd1,
    ACT_SKIN = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  localparam int unsigned MatElems    = 16;
  localparam logic [7:0]  UnboundBone = 8'd255;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         bone_a;
    logic [7:0]         bone_b;
    logic [7:0]         bone_c;
    logic [7:0]         bone_d;
    logic [16:0]        weight_a;
    logic [16:0]        weight_b;
    logic [16:0]        weight_c;
    logic [16:0]        weight_d;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               skipped;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic               live;
    logic               unbound;
    logic [16:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } stage_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clamp_t;

  function automatic clamp_t clamp32(input logic signed [49:0] v);
    clamp_t r;
    if (v > 50'sd2147483647) begin
      r.val = 32'sh7FFFFFFF;
      r.sat = 1'b1;
    end else if (v < -50'sd2147483648) begin
      r.val = 32'sh80000000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lbs_tables.sv */
// ----------------------------------------------------------------------------
// Bone matrix tables
// Pose and inverse bind memories, one word written per transfer, one whole
// matrix read per cycle from each while rd_en_i is high, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_tables #(
  parameter int unsigned BONE_COUNT = 64,
  localparam int unsigned BoneW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_pose_i,
  input  wire logic                     we_inv_i,
  input  wire logic [BoneW-1:0]         wr_bone_i,
  input  wire logic [3:0]               wr_elem_i,
  input  wire logic [31:0]              wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [BoneW-1:0]         rd_bone_i,
  output logic      [31:0]              pose_row_o [lbs_pkg::MatElems],
  output logic      [31:0]              inv_row_o  [lbs_pkg::MatElems]
);

  logic [31:0] pose_mem [BONE_COUNT][lbs_pkg::MatElems];
  logic [31:0] inv_mem  [BONE_COUNT][lbs_pkg::MatElems];

  always_ff @(posedge clk_i) begin
    if (we_pose_i) begin
      pose_mem[wr_bone_i][wr_elem_i] <= wr_data_i;
    end
    if (we_inv_i) begin
      inv_mem[wr_bone_i][wr_elem_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      pose_row_o <= pose_mem[rd_bone_i];
      inv_row_o  <= inv_mem[rd_bone_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/linear_blend_skinning.sv */
// ----------------------------------------------------------------------------
// Four-bone linear blend skinning
// Blends four bone matrices (pose times inverse bind) by Q1.16 weights and
// transforms a Q16.16 vertex by the blend, with saturation.
//
//   Channel | Signals                        | Transfer
//   --------+--------------------------------+-------------------------------
//   in      | in_valid_i in_ready_o in_data_i | load, skin or no-op item
//   out     | out_valid_o out_ready_i out_data_o | one result per skin item
//
// A load or no-op item needs only its transfer; a skin item then blocks the
// input while its four bone slots issue in turn, since each table gives one
// bone matrix per cycle while the pipeline runs. The result passes the table
// read, product, matrix, weight, accumulate, blend, vertex and output stages.
// Reset clears issue and valid state; the tables are undefined until loaded.
// A stall on the output freezes the whole pipeline and the table read port.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_skinning #(
  parameter int unsigned BONE_COUNT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lbs_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lbs_pkg::out_item_t     out_data_o
);

  localparam int unsigned BoneW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
  localparam logic [7:0]  BoneLimit = 8'(BONE_COUNT);

  logic en, in_acc, wr_ok, we_pose, we_inv;
  logic busy_q, busy_d;
  logic [1:0] slot_q, slot_d;
  lbs_pkg::in_item_t cur_q, cur_d;
  lbs_pkg::stage_t ctl0, ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q, ctl7_q;
  logic [7:1] vld_q;
  logic [7:0] slot_bone;
  logic [16:0] slot_weight;
  logic [BoneW-1:0] rd_bone;
  logic [31:0] pose_row [lbs_pkg::MatElems];
  logic [31:0] inv_row  [lbs_pkg::MatElems];

  logic signed [63:0] prod_q [lbs_pkg::MatElems][4];
  logic signed [31:0] m_q    [lbs_pkg::MatElems];
  logic signed [31:0] m_d    [lbs_pkg::MatElems];
  logic               msat_q, msat_d;
  logic signed [49:0] wp_q   [lbs_pkg::MatElems];
  logic               sat4_q;
  logic signed [35:0] acc_q  [lbs_pkg::MatElems];
  logic signed [35:0] acc_d  [lbs_pkg::MatElems];
  logic               sacc_q, sacc_d;
  logic signed [31:0] b_q    [lbs_pkg::MatElems];
  logic signed [31:0] b_d    [lbs_pkg::MatElems];
  logic               bsat_q, bsat_d;
  logic signed [63:0] q_q    [3][3];
  logic signed [31:0] b3_q   [3];
  logic               sat7_q;
  logic               out_valid_q;
  lbs_pkg::out_item_t out_q, out_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en && !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_ok      = in_acc && (in_data_i.bone_a < BoneLimit) &&
                      (in_data_i.bone_b < 8'(lbs_pkg::MatElems));
  assign we_pose    = wr_ok && (in_data_i.action == lbs_pkg::ACT_POSE);
  assign we_inv     = wr_ok && (in_data_i.action == lbs_pkg::ACT_INV);

  always_comb begin
    case (slot_q)
      2'd0: begin
        slot_bone = cur_q.bone_a;
        slot_weight = cur_q.weight_a;
      end
      2'd1: begin
        slot_bone = cur_q.bone_b;
        slot_weight = cur_q.weight_b;
      end
      2'd2: begin
        slot_bone = cur_q.bone_c;
        slot_weight = cur_q.weight_c;
      end
      default: begin
        slot_bone = cur_q.bone_d;
        slot_weight = cur_q.weight_d;
      end
    endcase
    ctl0.first   = (slot_q == 2'd0);
    ctl0.last    = (slot_q == 2'd3);
    ctl0.unbound = (cur_q.bone_a == lbs_pkg::UnboundBone);
    ctl0.live    = (slot_bone < BoneLimit) && !ctl0.unbound;
    ctl0.weight  = slot_weight;
    ctl0.pos_x   = cur_q.pos_x;
    ctl0.pos_y   = cur_q.pos_y;
    ctl0.pos_z   = cur_q.pos_z;
    rd_bone      = ctl0.live ? slot_bone[BoneW-1:0] : '0;
  end

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    cur_d  = cur_q;
    if (in_acc && (in_data_i.action == lbs_pkg::ACT_SKIN)) begin
      busy_d = 1'b1;
      slot_d = 2'd0;
      cur_d  = in_data_i;
    end else if (busy_q) begin
      slot_d = slot_q + 2'd1;
      if (slot_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  lbs_tables #(
    .BONE_COUNT(BONE_COUNT)
  ) u_tables (
    .clk_i      (clk_i),
    .we_pose_i  (we_pose),
    .we_inv_i   (we_inv),
    .wr_bone_i  (in_data_i.bone_a[BoneW-1:0]),
    .wr_elem_i  (in_data_i.bone_b[3:0]),
    .wr_data_i  (in_data_i.pos_x),
    .rd_en_i    (en),
    .rd_bone_i  (rd_bone),
    .pose_row_o (pose_row),
    .inv_row_o  (inv_row)
  );

  always_comb begin
    logic signed [63:0] t;
    logic signed [49:0] s;
    lbs_pkg::clamp_t    c;
    msat_d = 1'b0;
    for (int e = 0; e < 16; e++) begin
      s = '0;
      for (int k = 0; k < 4; k++) begin
        t = prod_q[e][k] + 64'sd32768;
        s = s + {{2{t[63]}}, t[63:16]};
      end
      c = lbs_pkg::clamp32(s);
      m_d[e] = c.val;
      msat_d = msat_d | c.sat;
    end
  end

  always_comb begin
    logic signed [49:0] t;
    sacc_d = ctl4_q.first ? sat4_q : (sacc_q | sat4_q);
    for (int e = 0; e < 16; e++) begin
      t = wp_q[e] + 50'sd32768;
      acc_d[e] = (ctl4_q.first ? 36'sd0 : acc_q[e]) + {{2{t[49]}}, t[49:16]};
    end
  end

  always_comb begin
    lbs_pkg::clamp_t c;
    bsat_d = sacc_q;
    for (int e = 0; e < 16; e++) begin
      c = lbs_pkg::clamp32({{14{acc_q[e][35]}}, acc_q[e]});
      b_d[e] = c.val;
      bsat_d = bsat_d | c.sat;
    end
  end

  always_comb begin
    logic signed [63:0] t;
    logic signed [49:0] s;
    lbs_pkg::clamp_t    c [3];
    for (int r = 0; r < 3; r++) begin
      s = {{18{b3_q[r][31]}}, b3_q[r]};
      for (int k = 0; k < 3; k++) begin
        t = q_q[r][k] + 64'sd32768;
        s = s + {{2{t[63]}}, t[63:16]};
      end
      c[r] = lbs_pkg::clamp32(s);
    end
    if (ctl7_q.unbound) begin
      out_d.out_x     = '0;
      out_d.out_y     = '0;
      out_d.out_z     = '0;
      out_d.skipped   = 1'b1;
      out_d.saturated = 1'b0;
    end else begin
      out_d.out_x     = c[0].val;
      out_d.out_y     = c[1].val;
      out_d.out_z     = c[2].val;
      out_d.skipped   = 1'b0;
      out_d.saturated = sat7_q | c[0].sat | c[1].sat | c[2].sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= 2'd0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      busy_q      <= busy_d;
      slot_q      <= slot_d;
      vld_q[1]    <= busy_q;
      vld_q[2]    <= vld_q[1];
      vld_q[3]    <= vld_q[2];
      vld_q[4]    <= vld_q[3];
      vld_q[5]    <= vld_q[4] && ctl4_q.last;
      vld_q[6]    <= vld_q[5];
      vld_q[7]    <= vld_q[6];
      out_valid_q <= vld_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cur_q  <= cur_d;
      ctl1_q <= ctl0;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
      ctl7_q <= ctl6_q;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) begin
            prod_q[r*4+c][k] <= $signed(pose_row[r*4+k]) * $signed(inv_row[k*4+c]);
          end
        end
      end
      m_q    <= m_d;
      msat_q <= msat_d;
      for (int e = 0; e < 16; e++) begin
        wp_q[e] <= ctl3_q.live ? $signed({1'b0, ctl3_q.weight}) * m_q[e] : 50'sd0;
      end
      sat4_q <= ctl3_q.live && msat_q;
      if (vld_q[4]) begin
        acc_q  <= acc_d;
        sacc_q <= sacc_d;
      end
      b_q    <= b_d;
      bsat_q <= bsat_d;
      for (int r = 0; r < 3; r++) begin
        q_q[r][0] <= b_q[r*4]   * ctl6_q.pos_x;
        q_q[r][1] <= b_q[r*4+1] * ctl6_q.pos_y;
        q_q[r][2] <= b_q[r*4+2] * ctl6_q.pos_z;
        b3_q[r]   <= b_q[r*4+3];
      end
      sat7_q <= bsat_q;
      out_q  <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o)
    else $error("input taken while a vertex is still being issued");

  a_skin_starts_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.action == lbs_pkg::ACT_SKIN) |=> busy_q)
    else $error("vertex transfer did not start slot issue");

  a_idle_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> slot_q == 2'd0)
    else $error("slot counter not cleared at end of vertex");

  a_skipped_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.skipped) |->
      (out_data_o.out_x == '0 && out_data_o.out_y == '0 &&
       out_data_o.out_z == '0 && !out_data_o.saturated))
    else $error("unbound vertex result carries data");

endmodule

`default_nettype wire
